### src/rds_pkg.sv
// rds_pkg: shared constants and fixed-point helpers for the 3d reaction-diffusion stencil
// used by rds_lap and reaction_diffusion_stencil_3d_top
// depends on nothing
`default_nettype none

package rds_pkg;

  localparam int DATA_W  = 32;
  localparam int COEF_W  = 31;
  localparam int GRID_W  = 7;
  localparam int NOISE_W = 16;
  localparam int CX_W    = 7;
  localparam int CZ_W    = 11;
  localparam int CFG_IW  = 3;

  localparam int MAX_X_DEF = 64;
  localparam int MAX_Y_DEF = 64;
  localparam int MAX_Z_DEF = 1024;

  // register indexes on the config port
  localparam logic [CFG_IW-1:0] REG_DIFF_U    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DIFF_V    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FEED      = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KILL      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TIME_STEP = 3'd4;
  localparam logic [CFG_IW-1:0] REG_NOISE_AMP = 3'd5;
  localparam logic [CFG_IW-1:0] REG_GRID_X    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_GRID_Y    = 3'd7;

  // reset values, q8.24
  localparam logic [COEF_W-1:0] DIFF_U_RST    = 31'd3355443;
  localparam logic [COEF_W-1:0] DIFF_V_RST    = 31'd1677722;
  localparam logic [COEF_W-1:0] FEED_RST      = 31'd335544;
  localparam logic [COEF_W-1:0] KILL_RST      = 31'd805306;
  localparam logic [COEF_W-1:0] TIME_STEP_RST = 31'd16777216;
  localparam logic [COEF_W-1:0] NOISE_AMP_RST = 31'd0;
  localparam logic [GRID_W-1:0] GRID_RST      = 7'd64;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

  // clip a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] x);
    logic signed [DATA_W-1:0] res;
    if (x > 65'sd2147483647) begin
      res = S32_MAX;
    end else if (x < -65'sd2147483648) begin
      res = S32_MIN;
    end else begin
      res = x[DATA_W-1:0];
    end
    return res;
  endfunction

  // q8.24 product: round half up at bit 24, then clip
  function automatic logic signed [DATA_W-1:0] mulq_rs(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = 65'(p) + 65'sd8388608;
    return sat32(t >>> 24);
  endfunction

  // q8.24 times q1.15: round half up at bit 15, then clip
  function automatic logic signed [DATA_W-1:0] noise_rs(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = 65'(p) + 65'sd16384;
    return sat32(t >>> 15);
  endfunction

endpackage

`default_nettype wire

### src/rds_ram.sv
// rds_ram: generic simple dual-read ram, one write port, registered reads
// read during write at the same address returns the old word; no dependencies
`default_nettype none

module rds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### src/rds_lap.sv
// rds_lap: pipelined 7-point laplacian divided by 6, round to nearest, ties away
// six register stages, advance on en; depends on rds_pkg
`default_nettype none

module rds_lap
  import rds_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [DATA_W-1:0] nb_l,
  input  wire logic signed [DATA_W-1:0] nb_r,
  input  wire logic signed [DATA_W-1:0] nb_dn,
  input  wire logic signed [DATA_W-1:0] nb_up,
  input  wire logic signed [DATA_W-1:0] nb_pp,
  input  wire logic signed [DATA_W-1:0] nb_in,
  input  wire logic signed [DATA_W-1:0] ctr,
  output logic signed [DATA_W-1:0]      lap
);

  // floor(t/3) for t < 2^33 as a*21845 + floor((a+b)/3), t = a*2^16 + b
  localparam logic [34:0] OVF_T  = 35'd6442450944;
  localparam logic [31:0] K21845 = 32'd21845;
  localparam logic [35:0] RCP3   = 36'd174763;

  logic signed [33:0] sa_r, sb_r;
  logic signed [34:0] c6_r;
  logic signed [35:0] su_r;
  logic [35:0]        m_w;
  logic [34:0]        t_w;
  logic [16:0]        hi_r;
  logic [15:0]        lo_r;
  logic [17:0]        sm_w;
  logic [35:0]        pr_w;
  logic [31:0]        qa_r;
  logic [16:0]        qs_r;
  logic [32:0]        q_r;
  logic [1:0]         fl4_r, fl5_r, fl6_r;   // {overflow, negative}
  logic signed [DATA_W-1:0] lap_r;

  always_comb begin
    m_w  = su_r[35] ? 36'(~su_r + 36'sd4) : 36'(su_r + 36'sd3);
    t_w  = m_w[35:1];
    sm_w = 18'(hi_r) + 18'(lo_r);
    pr_w = 36'(sm_w) * RCP3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r  <= 34'(nb_l) + 34'(nb_r) + 34'(nb_dn);
      sb_r  <= 34'(nb_up) + 34'(nb_pp) + 34'(nb_in);
      c6_r  <= (35'(ctr) <<< 2) + (35'(ctr) <<< 1);
      su_r  <= 36'(sa_r) + 36'(sb_r) - 36'(c6_r);
      fl4_r <= {(t_w >= OVF_T), su_r[35]};
      hi_r  <= t_w[32:16];
      lo_r  <= t_w[15:0];
      qa_r  <= 32'(hi_r) * K21845;
      qs_r  <= pr_w[35:19];
      fl5_r <= fl4_r;
      q_r   <= 33'(qa_r) + 33'(qs_r);
      fl6_r <= fl5_r;
      if (fl6_r[1]) begin
        lap_r <= fl6_r[0] ? S32_MIN : S32_MAX;
      end else if (fl6_r[0]) begin
        lap_r <= -$signed(q_r[DATA_W-1:0]);
      end else begin
        lap_r <= $signed(q_r[DATA_W-1:0]);
      end
    end
  end

  assign lap = lap_r;

endmodule

`default_nettype wire

### src/reaction_diffusion_stencil_3d_top.sv
// reaction_diffusion_stencil_3d_top: 3d gray-scott update on a streamed padded grid
// depends on rds_pkg, rds_ram (plane stores) and rds_lap (laplacian pipeline)
//
//   channel | dir | handshake           | word
//   in_     | in  | in_valid / in_stall | u_value, v_value, noise_sample, frame_start
//   out_    | out | out_valid/out_stall | new_u, new_v, cell_x, cell_y, cell_z
//   cfg_    | in  | cfg_we              | cfg_index, cfg_wdata
//
// one word per cycle in while in_stall is low; out_valid follows the word through the
// arithmetic pipeline (laplacian divide and two chained q8.24 multiplies)
// the whole pipeline advances together when the output register is empty or taken,
// so in_stall follows out_stall in the same cycle and nothing is dropped or repeated
// rst_n (sync) clears counters, valid bits and config registers; the plane stores
// (three copies, u and v side by side) are not cleared and need no clearing pass
`default_nettype none

module reaction_diffusion_stencil_3d_top
  import rds_pkg::*;
#(
  parameter int MAX_X = MAX_X_DEF,
  parameter int MAX_Y = MAX_Y_DEF,
  parameter int MAX_Z = MAX_Z_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [DATA_W-1:0]  in_u_value,
  input  wire logic signed [DATA_W-1:0]  in_v_value,
  input  wire logic signed [NOISE_W-1:0] in_noise_sample,
  input  wire logic                      in_frame_start,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [DATA_W-1:0]       out_new_u,
  output logic signed [DATA_W-1:0]       out_new_v,
  output logic [CX_W-1:0]                out_cell_x,
  output logic [CX_W-1:0]                out_cell_y,
  output logic [CZ_W-1:0]                out_cell_z,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IW-1:0]         cfg_index,
  input  wire logic [COEF_W-1:0]         cfg_wdata
);

  localparam int ROW_W   = MAX_X + 2;
  localparam int PLANE_W = ROW_W * (MAX_Y + 2);
  localparam int DEPTH   = 2 * PLANE_W;
  localparam int AW      = $clog2(DEPTH);
  localparam int XW      = $clog2(MAX_X + 2);
  localparam int YW      = $clog2(MAX_Y + 2);
  localparam int PW      = $clog2(MAX_Z + 3);
  localparam int NS      = 13;   // last pipeline stage before the output register

  // per-cell side data that rides along the pipeline
  typedef struct packed {
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
    logic [CX_W-1:0]          cx;
    logic [CX_W-1:0]          cy;
    logic [CZ_W-1:0]          cz;
  } side_t;

  // reaction terms waiting for the diffusion part
  typedef struct packed {
    logic signed [DATA_W-1:0] uvv;
    logic signed [DATA_W-1:0] fu;
    logic signed [DATA_W-1:0] fkv;
    logic signed [DATA_W-1:0] nz;
  } react_t;

  // config registers
  logic [COEF_W-1:0] diff_u_r, diff_v_r, feed_r, kill_r, dt_r, noise_amp_r;
  logic [GRID_W-1:0] grid_x_r, grid_y_r;

  // stream position
  logic [XW-1:0] col_r, col_nxt, pos_x, gx_p1;
  logic [YW-1:0] row_r, row_nxt, pos_y, gy_p1;
  logic [PW-1:0] pl_r, pl_nxt, pos_p;
  logic          adv, accept, ignore, interior;

  // store addressing
  logic [AW-1:0] off, a_cur, a_mid;
  logic [AW-1:0] ra_a [3];
  logic [AW-1:0] ra_b [3];
  logic [63:0]   rd_a [3];
  logic [63:0]   rd_b [3];

  // stage 1
  logic [NS:1]               vld_r;
  logic signed [DATA_W-1:0]  in_u_r, in_v_r;
  logic signed [NOISE_W-1:0] noise_r;
  logic [CX_W-1:0]           cx1_r, cy1_r;
  logic [CZ_W-1:0]           cz1_r;
  logic signed [DATA_W-1:0]  u_c, v_c, lap_u, lap_v;

  side_t  side_r [2:NS];
  react_t rc_r   [5:10];

  logic signed [63:0]       uvp_r, nzp_r, fup_r, fkvp_r, uvvp_r;
  logic signed [63:0]       dlup_r, dlvp_r, dup_r, dvp_r;
  logic signed [DATA_W-1:0] omu_r, fk_r, uvq_r, nz_r, fu_r, fkv_r, nz4_r;
  logic signed [DATA_W-1:0] dlu_r, dlv_r, du0_r, dv0_r, du_r, dv1_r, duq_r, dvq_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_u_r, out_v_r;
  logic [CX_W-1:0]          out_x_r, out_y_r;
  logic [CZ_W-1:0]          out_z_r;

  assign adv      = !out_valid_r || !out_stall;
  assign accept   = in_valid && adv;
  assign in_stall = !adv;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_u_r    <= DIFF_U_RST;
      diff_v_r    <= DIFF_V_RST;
      feed_r      <= FEED_RST;
      kill_r      <= KILL_RST;
      dt_r        <= TIME_STEP_RST;
      noise_amp_r <= NOISE_AMP_RST;
      grid_x_r    <= GRID_RST;
      grid_y_r    <= GRID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIFF_U:    diff_u_r    <= cfg_wdata;
        REG_DIFF_V:    diff_v_r    <= cfg_wdata;
        REG_FEED:      feed_r      <= cfg_wdata;
        REG_KILL:      kill_r      <= cfg_wdata;
        REG_TIME_STEP: dt_r        <= cfg_wdata;
        REG_NOISE_AMP: noise_amp_r <= cfg_wdata;
        REG_GRID_X:    grid_x_r    <= cfg_wdata[GRID_W-1:0];
        REG_GRID_Y:    grid_y_r    <= cfg_wdata[GRID_W-1:0];
      endcase
    end
  end

  // grid size clamped to 1..MAX, kept as size+1 (last interior index + 1)
  always_comb begin
    if (grid_x_r == '0) begin
      gx_p1 = XW'(2);
    end else if (32'(grid_x_r) > MAX_X) begin
      gx_p1 = XW'(MAX_X + 1);
    end else begin
      gx_p1 = XW'(32'(grid_x_r) + 1);
    end
    if (grid_y_r == '0) begin
      gy_p1 = YW'(2);
    end else if (32'(grid_y_r) > MAX_Y) begin
      gy_p1 = YW'(MAX_Y + 1);
    end else begin
      gy_p1 = YW'(32'(grid_y_r) + 1);
    end
  end

  // position of the arriving word; frame_start restarts the raster
  always_comb begin
    pos_x    = in_frame_start ? '0 : col_r;
    pos_y    = in_frame_start ? '0 : row_r;
    pos_p    = in_frame_start ? '0 : pl_r;
    // past the last plane: words are swallowed
    ignore   = pos_p >= PW'(MAX_Z + 2);
    interior = !ignore && (pos_p >= PW'(2)) && (pos_x != '0) && (pos_x < gx_p1)
               && (pos_y != '0) && (pos_y < gy_p1);
    col_nxt  = pos_x;
    row_nxt  = pos_y;
    pl_nxt   = pos_p;
    if (!ignore) begin
      if (pos_x >= gx_p1) begin
        col_nxt = '0;
        if (pos_y >= gy_p1) begin
          row_nxt = '0;
          pl_nxt  = pos_p + PW'(1);
        end else begin
          row_nxt = pos_y + YW'(1);
        end
      end else begin
        col_nxt = pos_x + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pl_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pl_r  <= pl_nxt;
    end
  end

  // two planes by parity; cur holds plane p-2 until overwritten by plane p
  always_comb begin
    off     = AW'(32'(pos_y) * ROW_W + 32'(pos_x));
    a_cur   = pos_p[0] ? off + AW'(PLANE_W) : off;
    a_mid   = pos_p[0] ? off : off + AW'(PLANE_W);
    ra_a[0] = a_mid;
    ra_b[0] = a_cur;
    ra_a[1] = a_mid - AW'(1);
    ra_b[1] = a_mid + AW'(1);
    ra_a[2] = a_mid - AW'(ROW_W);
    ra_b[2] = a_mid + AW'(ROW_W);
  end

  // three identical copies give six reads a cycle when a word is accepted; all written with the same word
  for (genvar c = 0; c < 3; c++) begin : g_store
    rds_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (DEPTH)
    ) u_store (
      .clk     (clk),
      .we      (accept && !ignore),
      .waddr   (a_cur),
      .wdata   ({in_u_value, in_v_value}),
      .re      (accept),
      .raddr_a (ra_a[c]),
      .raddr_b (ra_b[c]),
      .rdata_a (rd_a[c]),
      .rdata_b (rd_b[c])
    );
  end

  assign u_c = $signed(rd_a[0][63:32]);
  assign v_c = $signed(rd_a[0][31:0]);

  rds_lap u_lap_u (
    .clk   (clk),
    .en    (adv),
    .nb_l  ($signed(rd_a[1][63:32])),
    .nb_r  ($signed(rd_b[1][63:32])),
    .nb_dn ($signed(rd_a[2][63:32])),
    .nb_up ($signed(rd_b[2][63:32])),
    .nb_pp ($signed(rd_b[0][63:32])),
    .nb_in (in_u_r),
    .ctr   (u_c),
    .lap   (lap_u)
  );

  rds_lap u_lap_v (
    .clk   (clk),
    .en    (adv),
    .nb_l  ($signed(rd_a[1][31:0])),
    .nb_r  ($signed(rd_b[1][31:0])),
    .nb_dn ($signed(rd_a[2][31:0])),
    .nb_up ($signed(rd_b[2][31:0])),
    .nb_pp ($signed(rd_b[0][31:0])),
    .nb_in (in_v_r),
    .ctr   (v_c),
    .lap   (lap_v)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NS-1:1], accept && interior};
      out_valid_r <= vld_r[NS];
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: incoming word, store reads land in the ram registers
      in_u_r  <= in_u_value;
      in_v_r  <= in_v_value;
      noise_r <= in_noise_sample;
      cx1_r   <= CX_W'(pos_x);
      cy1_r   <= CX_W'(pos_y);
      cz1_r   <= CZ_W'(pos_p - PW'(1));

      // stage 2
      side_r[2] <= '{u: u_c, v: v_c, cx: cx1_r, cy: cy1_r, cz: cz1_r};
      uvp_r     <= 64'(u_c) * 64'(v_c);
      omu_r     <= sat32(65'sd16777216 - 65'(u_c));
      fk_r      <= sat32($signed(65'(feed_r) + 65'(kill_r)));
      nzp_r     <= 64'($signed({1'b0, noise_amp_r})) * 64'(noise_r);

      // stage 3
      uvq_r  <= mulq_rs(uvp_r);
      fup_r  <= 64'($signed({1'b0, feed_r})) * 64'(omu_r);
      fkvp_r <= 64'(fk_r) * 64'($signed(side_r[2].v));
      nz_r   <= noise_rs(nzp_r);

      // stage 4: u*v*v second multiply
      uvvp_r <= 64'(uvq_r) * 64'($signed(side_r[3].v));
      fu_r   <= mulq_rs(fup_r);
      fkv_r  <= mulq_rs(fkvp_r);
      nz4_r  <= nz_r;

      // stage 5: reaction terms done, held until the laplacian catches up
      rc_r[5].uvv <= mulq_rs(uvvp_r);
      rc_r[5].fu  <= fu_r;
      rc_r[5].fkv <= fkv_r;
      rc_r[5].nz  <= nz4_r;
      for (int k = 6; k <= 10; k++) begin
        rc_r[k] <= rc_r[k-1];
      end
      for (int k = 3; k <= NS; k++) begin
        side_r[k] <= side_r[k-1];
      end

      // stage 8: diffusion scale on the laplacian from stage 7
      dlup_r <= 64'($signed({1'b0, diff_u_r})) * 64'(lap_u);
      dlvp_r <= 64'($signed({1'b0, diff_v_r})) * 64'(lap_v);

      // stage 9
      dlu_r <= mulq_rs(dlup_r);
      dlv_r <= mulq_rs(dlvp_r);

      // stage 10: derivatives before noise
      du0_r <= sat32(65'(dlu_r) - 65'($signed(rc_r[9].uvv)) + 65'($signed(rc_r[9].fu)));
      dv0_r <= sat32(65'(dlv_r) + 65'($signed(rc_r[9].uvv)) - 65'($signed(rc_r[9].fkv)));

      // stage 11: noise goes into du only
      du_r  <= sat32(65'(du0_r) + 65'($signed(rc_r[10].nz)));
      dv1_r <= dv0_r;

      // stage 12-13: times dt
      dup_r <= 64'(du_r) * 64'($signed({1'b0, dt_r}));
      dvp_r <= 64'(dv1_r) * 64'($signed({1'b0, dt_r}));
      duq_r <= mulq_rs(dup_r);
      dvq_r <= mulq_rs(dvp_r);

      // output register: euler step
      out_u_r <= sat32(65'($signed(side_r[NS].u)) + 65'(duq_r));
      out_v_r <= sat32(65'($signed(side_r[NS].v)) + 65'(dvq_r));
      out_x_r <= side_r[NS].cx;
      out_y_r <= side_r[NS].cy;
      out_z_r <= side_r[NS].cz;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_new_u  = out_u_r;
  assign out_new_v  = out_v_r;
  assign out_cell_x = out_x_r;
  assign out_cell_y = out_y_r;
  assign out_cell_z = out_z_r;

endmodule

`default_nettype wire

### tb/tb_reaction_diffusion_stencil_3d_top.sv
// tb_reaction_diffusion_stencil_3d_top: self-checking bench for the 3d gray-scott stencil
// streams padded grids under random idling and compares every updated cell
// depends on rds_pkg and reaction_diffusion_stencil_3d_top
`timescale 1ns / 100ps

module tb_reaction_diffusion_stencil_3d_top;
  import rds_pkg::*;

  localparam int ROW_LEN   = MAX_X_DEF + 2;
  localparam int PLANE_LEN = (MAX_X_DEF + 2) * (MAX_Y_DEF + 2);
  localparam int PLANE_CAP = MAX_Z_DEF + 2;
  localparam int SETTLE    = 20;    // longer than the pipeline takes to drain
  localparam int IDLE_MAX  = 4000;  // cycles without any handshake
  localparam int HOLD_LEN  = 300;   // one long receiver hold-off

  typedef struct {
    logic signed [DATA_W-1:0]  u;
    logic signed [DATA_W-1:0]  v;
    logic signed [NOISE_W-1:0] ns;
    logic                      fs;
  } cell_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
    logic [CX_W-1:0]          x;
    logic [CX_W-1:0]          y;
    logic [CZ_W-1:0]          z;
  } cell_update_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [DATA_W-1:0]  in_u_value = '0;
  logic signed [DATA_W-1:0]  in_v_value = '0;
  logic signed [NOISE_W-1:0] in_noise_sample = '0;
  logic                      in_frame_start = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_new_u;
  logic signed [DATA_W-1:0]  out_new_v;
  logic [CX_W-1:0]           out_cell_x;
  logic [CX_W-1:0]           out_cell_y;
  logic [CZ_W-1:0]           out_cell_z;
  logic                      cfg_we = 1'b0;
  logic [CFG_IW-1:0]         cfg_index = '0;
  logic [COEF_W-1:0]         cfg_wdata = '0;

  reaction_diffusion_stencil_3d_top uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // words waiting for the driver, and cell updates still owed by the block
  cell_word_t   cell_q[$];
  cell_update_t update_q[$];
  int           fails = 0;
  int           words_sent = 0;
  bit           hold_go = 1'b0;

  // -------------------------------------------------------------------------
  // shadow of the block: register file, plane stores and raster position
  // -------------------------------------------------------------------------
  longint      du_coef, dv_coef, feed, kill, dt, noise_amp;
  int          grid_x_raw, grid_y_raw;
  logic [31:0] u_store[2*PLANE_LEN];
  logic [31:0] v_store[2*PLANE_LEN];
  int          col, row, pln;

  function automatic longint clip32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // q8.24 product, rounded half up
  function automatic longint q24mul(longint a, longint b);
    return clip32((a * b + (64'sd1 <<< 23)) >>> 24);
  endfunction

  // laplacian sum divided by 6, ties away from zero
  function automatic longint div6(longint n);
    if (n >= 0) return clip32((n + 3) / 6);
    return clip32(-((-n + 3) / 6));
  endfunction

  function automatic int eff_grid(int raw, int lim);
    if (raw < 1) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  function automatic longint stored(logic [31:0] w);
    return longint'($signed(w));
  endfunction

  // one accepted word: update the shadow and queue the cell update it causes
  function automatic void model_word(cell_word_t w);
    int           gx, gy, cur, mid;
    longint       uc, vc, su, sv, uvv, fu, fk, nz, du, dv;
    cell_update_t e;
    gx = eff_grid(grid_x_raw, MAX_X_DEF);
    gy = eff_grid(grid_y_raw, MAX_Y_DEF);
    if (w.fs) begin
      col = 0; row = 0; pln = 0;
    end
    if (pln >= PLANE_CAP) return;
    cur = (pln & 1) * PLANE_LEN + row * ROW_LEN + col;
    if (pln >= 2 && col >= 1 && col <= gx && row >= 1 && row <= gy) begin
      mid = ((pln - 1) & 1) * PLANE_LEN + row * ROW_LEN + col;
      uc = stored(u_store[mid]);
      vc = stored(v_store[mid]);
      su = stored(u_store[mid-1]) + stored(u_store[mid+1]) + stored(u_store[mid-ROW_LEN])
         + stored(u_store[mid+ROW_LEN]) + stored(u_store[cur]) + longint'(w.u) - 6 * uc;
      sv = stored(v_store[mid-1]) + stored(v_store[mid+1]) + stored(v_store[mid-ROW_LEN])
         + stored(v_store[mid+ROW_LEN]) + stored(v_store[cur]) + longint'(w.v) - 6 * vc;
      uvv = q24mul(q24mul(uc, vc), vc);
      fu  = q24mul(feed, clip32((64'sd1 <<< 24) - uc));
      fk  = clip32(feed + kill);
      nz  = clip32((noise_amp * longint'(w.ns) + (64'sd1 <<< 14)) >>> 15);
      du  = clip32(q24mul(du_coef, div6(su)) - uvv + fu);
      dv  = clip32(q24mul(dv_coef, div6(sv)) + uvv - q24mul(fk, vc));
      du  = clip32(du + nz);
      e.u = DATA_W'(clip32(uc + q24mul(du, dt)));
      e.v = DATA_W'(clip32(vc + q24mul(dv, dt)));
      e.x = CX_W'(col);
      e.y = CX_W'(row);
      e.z = CZ_W'(pln - 1);
      update_q.push_back(e);
    end
    u_store[cur] = w.u;
    v_store[cur] = w.v;
    if (col + 1 >= gx + 2) begin
      col = 0;
      if (row + 1 >= gy + 2) begin
        row = 0;
        pln++;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
  endfunction

  // calm stretches: both sides run without gaps for a while
  function automatic bit calm();
    return ((words_sent / 150) % 4) == 3;
  endfunction

  // -------------------------------------------------------------------------
  // driver: offers queued words, random gap after each word
  // -------------------------------------------------------------------------
  int         gap_left = 0;
  cell_word_t drv_w;
  logic       drv_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        drv_w.u  = in_u_value;
        drv_w.v  = in_v_value;
        drv_w.ns = in_noise_sample;
        drv_w.fs = in_frame_start;
        model_word(drv_w);
        words_sent++;
      end
      if (in_valid && in_stall) begin
        drv_next = 1'b1;  // stalled word stays put
      end else if (gap_left > 0) begin
        gap_left--;
        drv_next = 1'b0;
      end else if (cell_q.size() > 0) begin
        drv_w = cell_q.pop_front();
        in_u_value      <= drv_w.u;
        in_v_value      <= drv_w.v;
        in_noise_sample <= drv_w.ns;
        in_frame_start  <= drv_w.fs;
        drv_next = 1'b1;
        gap_left = calm() ? 0 : $urandom_range(0, 6);
      end else begin
        drv_next = 1'b0;
      end
      in_valid <= drv_next;
    end
  end

  // -------------------------------------------------------------------------
  // monitor: random stall after each word, one long hold-off on request
  // -------------------------------------------------------------------------
  int           stall_left = 0;
  int           hold_left = 0;
  bit           hold_used = 1'b0;
  cell_update_t exp_w;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (update_q.size() == 0) begin
          $error("unexpected cell update x=%0d y=%0d z=%0d", out_cell_x, out_cell_y,
                 out_cell_z);
          fails++;
        end else begin
          exp_w = update_q.pop_front();
          if (out_new_u !== exp_w.u) begin
            $error("new_u: expected %0d, got %0d", exp_w.u, out_new_u);
            fails++;
          end
          if (out_new_v !== exp_w.v) begin
            $error("new_v: expected %0d, got %0d", exp_w.v, out_new_v);
            fails++;
          end
          if (out_cell_x !== exp_w.x) begin
            $error("cell_x: expected %0d, got %0d", exp_w.x, out_cell_x);
            fails++;
          end
          if (out_cell_y !== exp_w.y) begin
            $error("cell_y: expected %0d, got %0d", exp_w.y, out_cell_y);
            fails++;
          end
          if (out_cell_z !== exp_w.z) begin
            $error("cell_z: expected %0d, got %0d", exp_w.z, out_cell_z);
            fails++;
          end
        end
        stall_left = calm() ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_go && !hold_used) begin
        hold_left = HOLD_LEN;
        hold_used = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("tb_reaction_diffusion_stencil_3d_top: FAIL");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  // concentration: all extremes when extreme is set, else mostly moderate values so the
  // arithmetic stays in range, some extremes and full-range words to hit the saturation paths
  function automatic logic signed [DATA_W-1:0] pick_conc(bit extreme);
    int sel;
    sel = extreme ? 0 : $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0: return S32_MAX;
          1: return S32_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      1: return $urandom;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 32'h0200_0000));
    endcase
  endfunction

  // queue one padded grid in raster order; nx and ny are the effective sizes
  task automatic add_frame(int nx, int ny, int planes, bit extreme);
    cell_word_t w;
    for (int z = 0; z < planes; z++) begin
      for (int y = 0; y < ny + 2; y++) begin
        for (int x = 0; x < nx + 2; x++) begin
          w.u  = pick_conc(extreme);
          w.v  = pick_conc(extreme);
          w.ns = extreme ? ((x + y + z) % 2 ? 16'sh7fff : 16'sh8000) : NOISE_W'($urandom);
          // a stray restart inside a frame is harmless while the grid is unchanged
          w.fs = (z == 0 && y == 0 && x == 0) || ($urandom_range(0, 399) == 0);
          cell_q.push_back(w);
        end
      end
    end
  endtask

  // block idle: nothing queued, nothing in flight, ghost cells drained too
  task automatic wait_idle();
    while (cell_q.size() > 0 || in_valid || update_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IW-1:0] idx, logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DIFF_U:    du_coef = val;
      REG_DIFF_V:    dv_coef = val;
      REG_FEED:      feed = val;
      REG_KILL:      kill = val;
      REG_TIME_STEP: dt = val;
      REG_NOISE_AMP: noise_amp = val;
      REG_GRID_X:    grid_x_raw = val[GRID_W-1:0];
      REG_GRID_Y:    grid_y_raw = val[GRID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // test sequence
  // -------------------------------------------------------------------------
  int gxr, gyr, phase_words;

  initial begin
    du_coef = DIFF_U_RST;  dv_coef = DIFF_V_RST;
    feed = FEED_RST;       kill = KILL_RST;
    dt = TIME_STEP_RST;    noise_amp = NOISE_AMP_RST;
    grid_x_raw = GRID_RST; grid_y_raw = GRID_RST;
    col = 0; row = 0; pln = 0;
    foreach (u_store[i]) begin
      u_store[i] = '0;
      v_store[i] = '0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset coefficients, smallest grid, extreme words and samples
    reg_write(REG_GRID_X, 1);
    reg_write(REG_GRID_Y, 1);
    reg_done();
    add_frame(1, 1, 3, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gxr = 127; gyr = 0;   end  // above max clamps to 64, zero acts as one
        1: begin gxr = 0;   gyr = 127; end
        default: begin
          gxr = $urandom_range(1, 6);
          gyr = $urandom_range(1, 6);
        end
      endcase
      reg_write(REG_GRID_X, gxr);
      reg_write(REG_GRID_Y, gyr);
      for (int r = 0; r < 6; r++) begin
        case (ph)
          0: reg_write(CFG_IW'(r), '1);
          1: reg_write(CFG_IW'(r), '0);
          default: reg_write(CFG_IW'(r), pick_coef());
        endcase
      end
      if (ph == 2) begin
        // typical time step and no noise, so results track real dynamics
        reg_write(REG_TIME_STEP, TIME_STEP_RST);
        reg_write(REG_NOISE_AMP, NOISE_AMP_RST);
      end
      reg_done();

      phase_words = 0;
      while (phase_words < 110) begin
        add_frame(eff_grid(gxr, MAX_X_DEF), eff_grid(gyr, MAX_Y_DEF), 3, 1'b0);
        phase_words = cell_q.size();
      end
      // let the receiver sit while words keep coming, filling the pipeline
      if (ph == 3) hold_go = 1'b1;
      wait_idle();
    end

    if (fails == 0) begin
      $display("tb_reaction_diffusion_stencil_3d_top: PASS");
    end else begin
      $display("tb_reaction_diffusion_stencil_3d_top: FAIL");
    end
    $finish;
  end

endmodule
